[design/tbhe_pkg.sv]
// Package for the target bearing unit: word types, pipeline sizes and the arctangent table.
package tbhe_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int CONV_STAGES   = 5;

    // 2^22 / CONV_DEN is the scale from 1e-7 degree to binary angle
    localparam logic [21:0] CONV_DEN   = 22'd3515625;
    // floor(2^55 / CONV_DEN)
    localparam logic [33:0] CONV_RECIP = 34'd10248191152;
    localparam logic [31:0] GAIN_Q30   = 32'd652032874;

    localparam logic [15:0] TURN_CDEG = 16'd36000;
    localparam int          HALF_CDEG = 18000;
    localparam int          FULL_CDEG = 36000;

    localparam logic CFG_TARGET_LATITUDE  = 1'b0;
    localparam logic CFG_TARGET_LONGITUDE = 1'b1;

    typedef struct packed {
        logic signed [30:0] own_latitude;
        logic signed [31:0] own_longitude;
        logic        [15:0] heading;
    } sample_t;

    typedef struct packed {
        logic        [15:0] bearing;
        logic signed [15:0] heading_error;
        logic               target_set;
    } result_t;

    typedef struct packed {
        logic [15:0] hdg;
        logic        set;
    } side_t;

    // arctan(2^-i) as a binary angle, 2^32 to the turn
    function automatic logic [31:0] atan_bam(input int i);
        case (i)
            0:  return 32'd536870912;
            1:  return 32'd316933406;
            2:  return 32'd167458907;
            3:  return 32'd85004756;
            4:  return 32'd42667331;
            5:  return 32'd21354465;
            6:  return 32'd10679838;
            7:  return 32'd5340245;
            8:  return 32'd2670163;
            9:  return 32'd1335086;
            10: return 32'd667544;
            11: return 32'd333772;
            12: return 32'd166886;
            13: return 32'd83443;
            14: return 32'd41721;
            15: return 32'd20860;
            16: return 32'd10430;
            17: return 32'd5215;
            18: return 32'd2607;
            19: return 32'd1303;
            20: return 32'd651;
            21: return 32'd325;
            22: return 32'd162;
            23: return 32'd81;
            24: return 32'd40;
            25: return 32'd20;
            26: return 32'd10;
            27: return 32'd5;
            28: return 32'd2;
            29: return 32'd1;
            default: return 32'd0;
        endcase
    endfunction

endpackage

[design/target_bearing_heading_error_unit.sv]
// Throughput: one word per cycle; a single pipeline enable stalls every stage together,
// so the only hold-up is a result that waits on result_stall.
// Angle conversion multiplies by a reciprocal over five stages, then three rotation CORDIC
// lanes, two registered multiply levels and one vectoring CORDIC.
// Reset clears the valid bits and both target registers; payload is not reset.
module target_bearing_heading_error_unit
    import tbhe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  sample_t     sample,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int CS  = CORDIC_STAGES;
    localparam int PR  = CONV_STAGES;
    localparam int NG  = PR + CS + 1;
    localparam int AP  = NG + 4;
    localparam int BR  = AP + CS + 1;
    localparam int LAT = BR + 2;
    localparam int CW  = 34;
    localparam int VW  = 37;

    localparam logic signed [CW-1:0] QUARTER = 34'sd1073741824;
    localparam logic signed [CW-1:0] HALF    = 34'sd2147483648;

    logic signed [30:0] tlat_reg;
    logic signed [31:0] tlon_reg;
    logic               en;

    logic [LAT-1:0] vld_reg;
    side_t          side_reg [LAT];

    logic        sg_reg  [CONV_STAGES][3];
    logic [32:0] mag_reg [3];
    logic [50:0] ph_reg  [3];
    logic [49:0] pl_reg  [3];
    logic [9:0]  nl_reg  [3][3];
    logic [31:0] qe_reg  [3];
    logic [31:0] qe4_reg [3];
    logic [31:0] pr_reg  [3];
    logic [31:0] qc_reg  [3];

    logic signed [CW-1:0] rx_reg [CS+1][3];
    logic signed [CW-1:0] ry_reg [CS+1][3];
    logic signed [CW-1:0] rz_reg [CS+1][3];
    logic                 rn_reg [CS+1][3];

    logic signed [31:0] s_reg [3];
    logic signed [31:0] c_reg [3];

    logic signed [63:0] yp_reg, ap_reg, bp_reg;
    logic signed [31:0] cd_reg;
    logic signed [63:0] bc_reg;
    logic signed [32:0] y2_reg, a2_reg;
    logic signed [33:0] xx_reg, yy_reg;

    logic signed [VW-1:0] vx_reg [CS+1];
    logic signed [VW-1:0] vy_reg [CS+1];
    logic        [31:0]   vz_reg [CS+1];
    logic                 vzero_reg [CS+1];

    logic [15:0] brg_reg;
    result_t     res_reg;

    // entry terms
    logic signed [32:0] lane_v [3];
    logic        [15:0] hdg_red;
    side_t              side_in;

    assign en           = !(vld_reg[LAT-1] && result_stall);
    assign sample_stall = !en;
    assign result_valid = vld_reg[LAT-1];
    assign result       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tlat_reg <= '0;
            tlon_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TARGET_LATITUDE:  tlat_reg <= cfg_data[30:0];
                CFG_TARGET_LONGITUDE: tlon_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        lane_v[0] = {{2{sample.own_latitude[30]}}, sample.own_latitude};
        lane_v[1] = {{2{tlat_reg[30]}}, tlat_reg};
        lane_v[2] = {tlon_reg[31], tlon_reg} - {sample.own_longitude[31], sample.own_longitude};
        hdg_red   = (sample.heading >= TURN_CDEG) ? sample.heading - TURN_CDEG : sample.heading;
        side_in.hdg = hdg_red;
        side_in.set = (tlat_reg != '0) && (tlon_reg != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], sample_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < LAT; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    // degree units to binary angle: |v| * 2^22 / 3515625 by a reciprocal multiply,
    // which lands on the quotient or one below; the remainder check fixes the estimate
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                logic [66:0] psum;
                logic [31:0] rem;
                psum = {ph_reg[l], 16'h0000} + {17'h0, pl_reg[l]};
                rem  = {nl_reg[2][l], 22'h0} - pr_reg[l];

                sg_reg[0][l] <= lane_v[l][32];
                mag_reg[l]   <= lane_v[l][32] ? 33'(-lane_v[l]) : 33'(lane_v[l]);

                ph_reg[l]    <= 51'(mag_reg[l][32:16]) * 51'(CONV_RECIP);
                pl_reg[l]    <= 50'(mag_reg[l][15:0]) * 50'(CONV_RECIP);
                nl_reg[0][l] <= mag_reg[l][9:0];

                qe_reg[l]    <= psum[64:33];
                nl_reg[1][l] <= nl_reg[0][l];

                pr_reg[l]    <= qe_reg[l] * {10'h0, CONV_DEN};
                qe4_reg[l]   <= qe_reg[l];
                nl_reg[2][l] <= nl_reg[1][l];

                qc_reg[l]    <= qe4_reg[l] + {31'h0, rem >= {10'h0, CONV_DEN}};

                for (int k = 1; k < CONV_STAGES; k++)
                    sg_reg[k][l] <= sg_reg[k-1][l];
            end
        end
    end

    // apply sign, fold into the right half-plane and load the rotation start vector
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                logic [31:0]          b;
                logic signed [CW-1:0] z;
                b = sg_reg[CONV_STAGES-1][l] ? 32'(-qc_reg[l]) : qc_reg[l];
                z = {{2{b[31]}}, b};
                rx_reg[0][l] <= {2'b00, GAIN_Q30};
                ry_reg[0][l] <= '0;
                if (z > QUARTER)
                begin
                    rz_reg[0][l] <= z - HALF;
                    rn_reg[0][l] <= 1'b1;
                end
                else if (z < -QUARTER)
                begin
                    rz_reg[0][l] <= z + HALF;
                    rn_reg[0][l] <= 1'b1;
                end
                else
                begin
                    rz_reg[0][l] <= z;
                    rn_reg[0][l] <= 1'b0;
                end
            end
        end
    end

    for (genvar i = 0; i < CS; i++) begin : g_rot
        localparam logic signed [CW-1:0] ATN = {2'b00, atan_bam(i)};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    if (rz_reg[i][l] >= 0)
                    begin
                        rx_reg[i+1][l] <= rx_reg[i][l] - (ry_reg[i][l] >>> i);
                        ry_reg[i+1][l] <= ry_reg[i][l] + (rx_reg[i][l] >>> i);
                        rz_reg[i+1][l] <= rz_reg[i][l] - ATN;
                    end
                    else
                    begin
                        rx_reg[i+1][l] <= rx_reg[i][l] + (ry_reg[i][l] >>> i);
                        ry_reg[i+1][l] <= ry_reg[i][l] - (rx_reg[i][l] >>> i);
                        rz_reg[i+1][l] <= rz_reg[i][l] + ATN;
                    end
                    rn_reg[i+1][l] <= rn_reg[i][l];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                s_reg[l] <= rn_reg[CS][l] ? 32'(-ry_reg[CS][l]) : ry_reg[CS][l][31:0];
                c_reg[l] <= rn_reg[CS][l] ? 32'(-rx_reg[CS][l]) : rx_reg[CS][l][31:0];
            end
        end
    end

    // lane 0: own latitude, lane 1: target latitude, lane 2: longitude difference
    logic signed [31:0] b32;
    logic signed [32:0] bcs;
    assign b32 = bp_reg[61:30];
    assign bcs = bc_reg[62:30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            yp_reg <= s_reg[2] * c_reg[1];
            ap_reg <= c_reg[0] * s_reg[1];
            bp_reg <= s_reg[0] * c_reg[1];
            cd_reg <= c_reg[2];

            bc_reg <= b32 * cd_reg;
            y2_reg <= yp_reg[62:30];
            a2_reg <= ap_reg[62:30];

            xx_reg <= {a2_reg[32], a2_reg} - {bcs[32], bcs};
            yy_reg <= {y2_reg[32], y2_reg};
        end
    end

    // atan2 set-up: mirror the left half-plane onto the right
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vzero_reg[0] <= (xx_reg == '0) && (yy_reg == '0);
            if (xx_reg < 0)
            begin
                vx_reg[0] <= -(VW'(xx_reg));
                vy_reg[0] <= -(VW'(yy_reg));
                vz_reg[0] <= 32'h8000_0000;
            end
            else
            begin
                vx_reg[0] <= VW'(xx_reg);
                vy_reg[0] <= VW'(yy_reg);
                vz_reg[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < CS; i++) begin : g_vec
        localparam logic [31:0] ATN = atan_bam(i);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (vy_reg[i] >= 0)
                begin
                    vx_reg[i+1] <= vx_reg[i] + (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] - (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] + ATN;
                end
                else
                begin
                    vx_reg[i+1] <= vx_reg[i] - (vy_reg[i] >>> i);
                    vy_reg[i+1] <= vy_reg[i] + (vx_reg[i] >>> i);
                    vz_reg[i+1] <= vz_reg[i] - ATN;
                end
                vzero_reg[i+1] <= vzero_reg[i];
            end
        end
    end

    // binary angle to centidegrees, rounding half up; a full turn wraps to zero
    logic [47:0] bprod;
    assign bprod = 48'(vzero_reg[CS] ? 32'd0 : vz_reg[CS]) * 48'(TURN_CDEG) + 48'h8000_0000;

    always_ff @(posedge clk)
    begin
        if (en)
            brg_reg <= (bprod[47:32] >= TURN_CDEG) ? 16'd0 : bprod[47:32];
    end

    logic signed [16:0] err;
    logic signed [16:0] err_fold;
    always_comb
    begin
        err = {1'b0, brg_reg} - {1'b0, side_reg[BR].hdg};
        if (err > 17'(HALF_CDEG))
            err_fold = err - 17'(FULL_CDEG);
        else if (err < -17'(HALF_CDEG))
            err_fold = err + 17'(FULL_CDEG);
        else
            err_fold = err;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg.target_set    <= side_reg[BR].set;
            res_reg.bearing       <= side_reg[BR].set ? brg_reg : 16'd0;
            res_reg.heading_error <= side_reg[BR].set ? err_fold[15:0] : 16'sd0;
        end
    end

endmodule

[design/tbhe_checker.sv]
// Port checker for the target bearing unit, bound to the top level.
module tbhe_checker
    import tbhe_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        sample_stall,
    input logic        result_valid,
    input logic        result_stall,
    input result_t     result
);

    // the pipeline stalls exactly when a finished word is held back
    a_stall_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall == (result_valid && result_stall))
        else $error("sample_stall does not track a held result");

    a_unset_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.target_set |->
            result.bearing == 16'd0 && result.heading_error == 16'sd0)
        else $error("unset target gave a non-zero result");

    a_bearing_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.bearing < TURN_CDEG)
        else $error("bearing beyond one turn");

    a_error_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $signed(result.heading_error) <= 16'sd18000 &&
                         $signed(result.heading_error) >= -16'sd18000)
        else $error("heading error outside half a turn");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result word changed");

endmodule

bind target_bearing_heading_error_unit tbhe_checker u_tbhe_checker (.*);

[tb/sv/tb.sv]
// Testbench for the target bearing and heading error unit: scoreboard, stimulus and checks.
`timescale 1ns / 100ps

module tb;
    import tbhe_pkg::*;

    class bearing_scoreboard;
        result_t     pending[$];
        logic [31:0] tgt_lat;
        logic [31:0] tgt_lon;
        int          mismatches;

        function new();
            tgt_lat    = '0;
            tgt_lon    = '0;
            mismatches = 0;
        endfunction

        function void set_target(logic idx, logic [31:0] value);
            if (idx == CFG_TARGET_LATITUDE)
                tgt_lat = {1'b0, value[30:0]};
            else
                tgt_lon = value;
        endfunction

        // 1e-7 degree to binary angle, truncated toward zero, modulo a turn
        function logic [31:0] deg7_to_bam(longint v);
            longint b;
            b = (v * 64'sd1073741824) / 64'sd900000000;
            return b[31:0];
        endfunction

        function void rotate(logic [31:0] ang, output longint s, output longint c);
            longint x, y, z, t;
            bit     flip;
            x = longint'(GAIN_Q30);
            y = 0;
            z = longint'({32'b0, ang});
            flip = 0;
            if (z >= 64'sd2147483648)
                z -= 64'sd4294967296;
            if (z > 64'sd1073741824)
            begin
                z -= 64'sd2147483648;
                flip = 1;
            end
            else if (z < -64'sd1073741824)
            begin
                z += 64'sd2147483648;
                flip = 1;
            end
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                if (z >= 0)
                begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    z -= longint'({32'b0, atan_bam(i)});
                end
                else
                begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    z += longint'({32'b0, atan_bam(i)});
                end
                x = t;
            end
            s = flip ? -y : y;
            c = flip ? -x : x;
        endfunction

        function logic [31:0] vector_angle(longint y, longint x);
            longint z, t;
            z = 0;
            if (x == 0 && y == 0)
                return '0;
            if (x < 0)
            begin
                x = -x;
                y = -y;
                z = 64'sd2147483648;
            end
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                if (y >= 0)
                begin
                    t = x + (y >>> i);
                    y = y - (x >>> i);
                    z += longint'({32'b0, atan_bam(i)});
                end
                else
                begin
                    t = x - (y >>> i);
                    y = y + (x >>> i);
                    z -= longint'({32'b0, atan_bam(i)});
                end
                x = t;
            end
            return z[31:0];
        endfunction

        function result_t bearing_for(sample_t s);
            result_t           r;
            longint            lat1, lon1, lat2, lon2, s1, c1, s2, c2, sd, cd, y, x, err;
            longint unsigned   brg, hdg;
            lat1 = longint'(s.own_latitude);
            lon1 = longint'(s.own_longitude);
            lat2 = longint'(signed'(tgt_lat[30:0]));
            lon2 = longint'(signed'(tgt_lon));
            hdg  = longint'({16'b0, s.heading}) % 36000;
            r = '0;
            if (lat2 == 0 || lon2 == 0)
                return r;
            rotate(deg7_to_bam(lat1), s1, c1);
            rotate(deg7_to_bam(lat2), s2, c2);
            rotate(deg7_to_bam(lon2 - lon1), sd, cd);
            y = (sd * c2) >>> 30;
            x = ((c1 * s2) >>> 30) - ((((s1 * c2) >>> 30) * cd) >>> 30);
            brg = ({32'b0, vector_angle(y, x)} * 64'd36000 + 64'd2147483648) >> 32;
            if (brg >= 36000)
                brg = 0;
            err = longint'(brg) - longint'(hdg);
            if (err > 18000)
                err -= 36000;
            else if (err < -18000)
                err += 36000;
            r.bearing       = brg[15:0];
            r.heading_error = err[15:0];
            r.target_set    = 1'b1;
            return r;
        endfunction

        function void note_sample(sample_t s);
            pending.push_back(bearing_for(s));
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("%0t: %s got %0d expected %0d", $time, what, got, want);
            mismatches++;
        endtask

        task check_result(result_t r);
            result_t e;
            if (pending.size() == 0)
            begin
                report("unexpected result word, bearing", r.bearing, 0);
                return;
            end
            e = pending.pop_front();
            if (r.bearing !== e.bearing)
                report("bearing", r.bearing, e.bearing);
            if (r.heading_error !== e.heading_error)
                report("heading_error", 32'(signed'(r.heading_error)),
                       32'(signed'(e.heading_error)));
            if (r.target_set !== e.target_set)
                report("target_set", r.target_set, e.target_set);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_stall;
    sample_t     sample;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        cfg_write;
    logic        cfg_index;
    logic [31:0] cfg_data;

    bearing_scoreboard sb = new();
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold;

    target_bearing_heading_error_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver: long hold-off on request, otherwise random stalls
    initial
    begin
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                result_stall = 1'b1;
                rx_hold--;
            end
            else
                result_stall = ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);

    task send_word(sample_t s);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            @(negedge clk);
            sample_valid = 1'b0;
        end
        @(negedge clk);
        sample_valid = 1'b1;
        sample       = s;
        do
            @(posedge clk);
        while (sample_stall);
        sb.note_sample(s);
    endtask

    task drain();
        @(negedge clk);
        sample_valid = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (90) @(negedge clk);
    endtask

    task write_target(logic idx, logic [31:0] value);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_write = 1'b0;
        sb.set_target(idx, value);
    endtask

    function sample_t make_sample(longint lat, longint lon, int hdg);
        sample_t s;
        s.own_latitude  = lat[30:0];
        s.own_longitude = lon[31:0];
        s.heading       = hdg[15:0];
        return s;
    endfunction

    function sample_t random_sample();
        longint lat, lon;
        if ($urandom_range(9) < 8)
        begin
            lat = longint'($urandom_range(1800000000)) - 900000000;
            lon = longint'($urandom_range(1800000000)) * 2 - 1800000000
                  + longint'($urandom_range(1));
            return make_sample(lat, lon, $urandom_range(35999));
        end
        return make_sample(longint'($urandom), longint'($urandom), $urandom_range(65535));
    endfunction

    task directed_words();
        longint lat2, lon2;
        lat2 = longint'(signed'(sb.tgt_lat[30:0]));
        lon2 = longint'(signed'(sb.tgt_lon));
        send_word(make_sample(900000000, 1800000000, 0));
        send_word(make_sample(-900000000, -1800000000, 35999));
        send_word(make_sample(0, 0, 36000));
        send_word(make_sample(1, -1, 65535));
        send_word(make_sample(-1073741824, -64'sd2147483648, 18000));
        send_word(make_sample(1073741823, 2147483647, 54000));
        // target at the vehicle and at its antipode
        send_word(make_sample(lat2, lon2, 12345));
        send_word(make_sample(-lat2, lon2 + 1800000000, 27000));
        send_word(make_sample(-lat2, lon2 - 1800000000, 9000));
        // straddle the fold boundary
        for (int i = 0; i < 4; i++)
            send_word(make_sample(lat2 - 1000, lon2, 18000 * (i % 2) + i));
        send_word(make_sample(lat2, lon2 + 5000, 27000));
        send_word(make_sample(lat2, lon2 - 5000, 27000));
    endtask

    initial
    begin
        longint lat_set[7];
        longint lon_set[7];
        int     sent;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        cfg_write    = 1'b0;
        cfg_index    = CFG_TARGET_LATITUDE;
        cfg_data     = '0;
        rx_hold      = 0;
        tx_idle_pct  = 21;
        rx_idle_pct  = 49;
        sent         = 0;
        lat_set = '{0, 412345678, 900000000, -900000000, 1, -123456789, 0};
        lon_set = '{0, 0, 1800000000, -1800000000, -1, 987654321, 291234567};
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < 9; p++)
        begin
            if (p >= 7)
            begin
                lat_set[p % 7] = longint'($urandom_range(1800000000)) - 900000000;
                lon_set[p % 7] = longint'($urandom_range(1800000000)) * 2 - 1800000000;
            end
            if (p > 0)
            begin
                write_target(CFG_TARGET_LATITUDE, lat_set[p % 7][31:0]);
                write_target(CFG_TARGET_LONGITUDE, lon_set[p % 7][31:0]);
            end
            if (p == 0 || p == 2)
                directed_words();
            if (p == 3)
                rx_hold = 300;
            for (int k = 0; k < 135; k++)
            begin
                if (sent < 400)
                begin
                    tx_idle_pct = 21;
                    rx_idle_pct = 49;
                end
                else if (sent < 800)
                begin
                    tx_idle_pct = 49;
                    rx_idle_pct = 21;
                end
                else
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                send_word(random_sample());
                sent++;
            end
            drain();
        end

        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
design/tbhe_pkg.sv
design/target_bearing_heading_error_unit.sv
design/tbhe_checker.sv
tb/sv/tb.sv
